[rtl/rpc_pkg.sv]
`timescale 1ns / 1ps
package rpc_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned BoundW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned AddrW = 6;
  localparam int unsigned CntW = 7;

  localparam logic [CfgIdxW-1:0] CfgLeft = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBottom = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRight = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTop = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     final_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] clipped_x;
    logic signed [CoordW-1:0] clipped_y;
    logic                     end_of_polygon;
    logic                     fully_clipped;
    logic                     vertices_dropped;
  } out_item_t;

endpackage

[rtl/rect_polygon_clipper.sv]
`timescale 1ns / 1ps
// Vertices load one per cycle. The item marked last starts up to four clipping passes (left,
// right, bottom, top; they stop once a pass leaves no vertex). Each edge crossing uses the one
// shared 50-step restoring divider; a crossing that enters the window also pushes the vertex.
// Results then follow one at a time, each held until taken; an empty polygon gives one marker.
// One polygon at a time; input stalls from the last vertex until its final result.
// Reset: asynchronous, active low; clears control, counts, output; window 0..639 x 0..479. Stores are not cleared.
module rect_polygon_clipper #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rpc_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rpc_pkg::out_item_t         out_data_o,
  input  logic                       cfg_we_i,
  input  logic [rpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rpc_pkg::BoundW-1:0] cfg_data_i
);
  import rpc_pkg::*;

  // Division: |num| < 2^48 (two 25-bit differences), divisor < 2^24.
  localparam int unsigned NumW = 50;
  localparam int unsigned DenW = 26;
  localparam int unsigned DivCntW = 6;

  typedef enum logic [11:0] {
    S_LOAD    = 12'b000000000001,
    S_START   = 12'b000000000010,
    S_PREV    = 12'b000000000100,
    S_READ    = 12'b000000001000,
    S_EVAL    = 12'b000000010000,
    S_ABS     = 12'b000000100000,
    S_DIV     = 12'b000001000000,
    S_PUSHX   = 12'b000010000000,
    S_PUSHC   = 12'b000100000000,
    S_EMIT_RD = 12'b001000000000,
    S_EMIT_LD = 12'b010000000000,
    S_EMIT_WT = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [BoundW-1:0] left_q, bottom_q, right_q, top_q;

  // Ping-pong stores; bank_q selects which store the current pass reads.
  logic [2*CoordW-1:0] mem_a [StoreDepth];
  logic [2*CoordW-1:0] mem_b [StoreDepth];
  logic [2*CoordW-1:0] rd_a_q, rd_b_q;

  logic [CntW-1:0] load_cnt_q;
  logic            ovf_q;
  logic [1:0]      edge_q;
  logic            bank_q;      // 0: read a, write b
  logic [CntW-1:0] n_q, idx_q, out_n_q;
  logic [CntW-1:0] n_m1, out_n_inc;
  logic [AddrW-1:0] rd_addr;
  logic            rd_en;

  logic signed [CoordW-1:0] px_q, py_q;
  logic            prev_in_q, cur_in;

  // Divider registers
  logic [NumW-1:0] rem_q, quo_q;
  logic [DenW-1:0] den_q;
  logic            neg_q;
  logic [DivCntW-1:0] dcnt_q;

  // Emit
  logic            emit_valid_q;
  out_item_t       emit_q;
  logic            drop_q;

  // Sequencer conditions
  logic            room, last_idx, advance, all_done;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      bottom_q <= '0;
      right_q  <= 16'sd639;
      top_q    <= 16'sd479;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLeft:   left_q   <= cfg_data_i;
        CfgBottom: bottom_q <= cfg_data_i;
        CfgRight:  right_q  <= cfg_data_i;
        CfgTop:    top_q    <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Bound of the current edge in Q15.8.
  logic signed [CoordW-1:0] bound;
  always_comb begin
    case (edge_q)
      2'd0:    bound = {left_q, 8'd0};
      2'd1:    bound = {right_q, 8'd0};
      2'd2:    bound = {bottom_q, 8'd0};
      default: bound = {top_q, 8'd0};
    endcase
  end

  // Inside test of the vertex held in the read register; boundary counts as inside.
  logic signed [CoordW-1:0] rd_x, rd_y;
  assign rd_x = bank_q ? rd_b_q[2*CoordW-1:CoordW] : rd_a_q[2*CoordW-1:CoordW];
  assign rd_y = bank_q ? rd_b_q[CoordW-1:0] : rd_a_q[CoordW-1:0];
  always_comb begin
    case (edge_q)
      2'd0:    cur_in = rd_x >= bound;
      2'd1:    cur_in = rd_x <= bound;
      2'd2:    cur_in = rd_y >= bound;
      default: cur_in = rd_y <= bound;
    endcase
  end

  // Crossing setup: one 25 x 25 signed multiply, registered before the divider starts.
  logic signed [CoordW:0] d_other, d_along, d_bnd;
  logic [CoordW:0]        den_abs;
  logic signed [NumW-1:0] prod;
  always_comb begin
    if (!edge_q[1]) begin
      d_other = {rd_y[CoordW-1], rd_y} - {py_q[CoordW-1], py_q};
      d_along = {rd_x[CoordW-1], rd_x} - {px_q[CoordW-1], px_q};
      d_bnd   = {bound[CoordW-1], bound} - {px_q[CoordW-1], px_q};
    end else begin
      d_other = {rd_x[CoordW-1], rd_x} - {px_q[CoordW-1], px_q};
      d_along = {rd_y[CoordW-1], rd_y} - {py_q[CoordW-1], py_q};
      d_bnd   = {bound[CoordW-1], bound} - {py_q[CoordW-1], py_q};
    end
    den_abs = d_along[CoordW] ? -d_along : d_along;
    prod = $signed({{(NumW-CoordW-1){d_other[CoordW]}}, d_other})
         * $signed({{(NumW-CoordW-1){d_bnd[CoordW]}}, d_bnd});
  end

  // Restoring divider step.
  logic [NumW:0] trial;
  assign trial = {rem_q, quo_q[NumW-1]} - {{(NumW-DenW+1){1'b0}}, den_q};

  // Quotient truncates toward zero: divide magnitudes, then apply the sign.
  logic signed [NumW-1:0] quo_s;
  logic signed [CoordW-1:0] cross_o;
  assign quo_s   = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign cross_o = (edge_q[1] ? px_q : py_q) + quo_s[CoordW-1:0];

  // Write port into the destination store.
  logic            wr_en;
  logic [2*CoordW-1:0] wr_data;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != S_LOAD);

  logic load_wr;
  assign load_wr = in_acc && (load_cnt_q < CntW'(MAX_VERTICES));

  assign n_m1 = n_q - CntW'(1);

  // Read address: the last vertex at pass start, else idx_q; emit reads store a.
  always_comb begin
    rd_addr = idx_q[AddrW-1:0];
    rd_en   = 1'b0;
    case (state_q)
      S_START: begin
        rd_addr = n_m1[AddrW-1:0];
        rd_en   = 1'b1;
      end
      S_PREV:    rd_en = 1'b1;
      S_READ:    rd_en = 1'b1;
      S_EMIT_RD: rd_en = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) mem_a[load_cnt_q[AddrW-1:0]] <= {in_data_i.vertex_x, in_data_i.vertex_y};
    else if (wr_en && bank_q) mem_a[out_n_q[AddrW-1:0]] <= wr_data;
    if (wr_en && !bank_q) mem_b[out_n_q[AddrW-1:0]] <= wr_data;
    if (rd_en) begin
      rd_a_q <= mem_a[rd_addr];
      rd_b_q <= mem_b[rd_addr];
    end
  end

  // Drop pushes once the destination store is full.
  assign room = out_n_q < CntW'(StoreDepth);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = {rd_x, rd_y};
    if (room) begin
      case (state_q)
        S_PUSHX: begin
          wr_en   = 1'b1;
          wr_data = edge_q[1] ? {cross_o, bound} : {bound, cross_o};
        end
        S_PUSHC: wr_en = 1'b1;
        S_EVAL:  wr_en = cur_in && (cur_in == prev_in_q);
        default: ;
      endcase
    end
  end

  assign out_n_inc = out_n_q + {{(CntW-1){1'b0}}, wr_en};

  // Advance to the next vertex once the current one is fully handled.
  always_comb begin
    case (state_q)
      S_EVAL:  advance = (cur_in == prev_in_q);
      S_PUSHX: advance = !cur_in;
      S_PUSHC: advance = 1'b1;
      default: advance = 1'b0;
    endcase
  end
  assign last_idx = (idx_q == n_m1);
  assign all_done = (edge_q == 2'd3) || (out_n_inc == '0);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:    if (in_acc && in_data_i.final_vertex) state_d = S_START;
      S_START:   state_d = S_PREV;
      S_PREV:    state_d = S_EVAL;
      S_READ:    state_d = S_EVAL;
      S_EVAL:    if (cur_in != prev_in_q) state_d = S_ABS;
      S_ABS:     state_d = S_DIV;
      S_DIV:     if (dcnt_q == '0) state_d = S_PUSHX;
      S_PUSHX:   if (cur_in) state_d = S_PUSHC;
      S_PUSHC:   ;
      S_EMIT_RD: state_d = S_EMIT_LD;
      S_EMIT_LD: state_d = S_EMIT_WT;
      S_EMIT_WT: begin
        if (out_acc) state_d = emit_q.end_of_polygon ? S_LOAD : S_EMIT_RD;
      end
      default:   state_d = S_LOAD;
    endcase
    if (advance) begin
      if (!last_idx) state_d = S_READ;
      else if (!all_done) state_d = S_START;
      else state_d = (out_n_inc == '0) ? S_EMIT_WT : S_EMIT_RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      load_cnt_q   <= '0;
      ovf_q        <= 1'b0;
      edge_q       <= '0;
      bank_q       <= 1'b0;
      n_q          <= '0;
      idx_q        <= '0;
      out_n_q      <= '0;
      prev_in_q    <= 1'b0;
      px_q         <= '0;
      py_q         <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      den_q        <= '0;
      neg_q        <= 1'b0;
      dcnt_q       <= '0;
      emit_valid_q <= 1'b0;
      emit_q       <= '0;
      drop_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (in_data_i.final_vertex) begin
              // Last vertex: latch the count and start the left pass from store a.
              n_q        <= load_wr ? load_cnt_q + CntW'(1) : load_cnt_q;
              drop_q     <= ovf_q || !load_wr;
              load_cnt_q <= '0;
              ovf_q      <= 1'b0;
              edge_q     <= 2'd0;
              bank_q     <= 1'b0;
              out_n_q    <= '0;
              idx_q      <= '0;
            end else if (load_wr) begin
              load_cnt_q <= load_cnt_q + CntW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        S_PREV: begin
          // The pass starts from the edge last vertex -> first vertex.
          prev_in_q <= cur_in;
          px_q      <= rd_x;
          py_q      <= rd_y;
        end
        S_EVAL: begin
          if (cur_in != prev_in_q) begin
            quo_q <= prod;
            den_q <= {{(DenW-CoordW-1){1'b0}}, den_abs};
            neg_q <= prod[NumW-1] ^ d_along[CoordW];
          end
        end
        S_ABS: begin
          if (quo_q[NumW-1]) quo_q <= -quo_q;
          rem_q  <= '0;
          dcnt_q <= DivCntW'(NumW - 1);
        end
        S_DIV: begin
          if (!trial[NumW]) begin
            rem_q <= trial[NumW-1:0];
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[NumW-2:0], quo_q[NumW-1]};
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q - 1'b1;
        end
        S_EMIT_LD: begin
          emit_valid_q <= 1'b1;
          emit_q <= '{clipped_x: rd_a_q[2*CoordW-1:CoordW],
                      clipped_y: rd_a_q[CoordW-1:0],
                      end_of_polygon: (idx_q == n_m1),
                      fully_clipped: 1'b0, vertices_dropped: drop_q};
        end
        S_EMIT_WT: begin
          // Hold the item until it is taken.
          if (out_acc) begin
            emit_valid_q <= 1'b0;
            if (!emit_q.end_of_polygon) idx_q <= idx_q + CntW'(1);
          end
        end
        default: ;
      endcase
      if (advance) begin
        prev_in_q <= cur_in;
        px_q      <= rd_x;
        py_q      <= rd_y;
        if (last_idx) begin
          // Pass done: swap banks; the four passes end in store a.
          n_q     <= out_n_inc;
          out_n_q <= '0;
          bank_q  <= ~bank_q;
          idx_q   <= '0;
          if (!all_done) edge_q <= edge_q + 2'd1;
          if (all_done && out_n_inc == '0) begin
            emit_valid_q <= 1'b1;
            emit_q <= '{clipped_x: '0, clipped_y: '0, end_of_polygon: 1'b1,
                        fully_clipped: 1'b1, vertices_dropped: drop_q};
          end
        end else begin
          out_n_q <= out_n_inc;
          idx_q   <= idx_q + CntW'(1);
        end
      end else if (wr_en) begin
        out_n_q <= out_n_inc;
      end
    end
  end

  assign out_valid_o = emit_valid_q;
  assign out_data_o  = emit_q;

endmodule

[test/rect_polygon_clipper_tb.sv]
`timescale 1ns / 1ps
module rect_polygon_clipper_tb;
  import rpc_pkg::*;

  localparam int MaxVertices = 16;
  localparam int WatchdogLimit = 60000;
  localparam int DrainCycles = 40;
  localparam int TargetItems = 210;

  typedef enum int {EdgeLeft, EdgeRight, EdgeBottom, EdgeTop} clip_edge_e;
  typedef struct {
    longint x;
    longint y;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = CfgLeft;
  logic [BoundW-1:0] cfg_data = '0;

  rect_polygon_clipper #(.MAX_VERTICES(MaxVertices)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the clip window, integer units.
  logic signed [BoundW-1:0] win_left = 16'sd0;
  logic signed [BoundW-1:0] win_bottom = 16'sd0;
  logic signed [BoundW-1:0] win_right = 16'sd639;
  logic signed [BoundW-1:0] win_top = 16'sd479;

  in_item_t vertex_feed[$];     // vertices waiting for the driver
  out_item_t clipped_expect[$]; // predicted clipped vertices, oldest first
  point_t polygon_pts[$];       // vertices loaded for the open polygon
  bit polygon_overflow;

  int mismatches = 0;
  int vertices_taken = 0;
  int results_seen = 0;
  int polygons_done = 0;
  int empty_markers = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit no_idle = 1'b0;
  bit in_took = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic longint edge_bound(clip_edge_e e);
    case (e)
      EdgeLeft:   return longint'(win_left) * 256;
      EdgeRight:  return longint'(win_right) * 256;
      EdgeBottom: return longint'(win_bottom) * 256;
      default:    return longint'(win_top) * 256;
    endcase
  endfunction

  function automatic bit on_inner_side(point_t p, clip_edge_e e);
    case (e)
      EdgeLeft:   return p.x >= edge_bound(e);
      EdgeRight:  return p.x <= edge_bound(e);
      EdgeBottom: return p.y >= edge_bound(e);
      default:    return p.y <= edge_bound(e);
    endcase
  endfunction

  // Crossing of segment p->c with the edge; division truncates toward zero.
  function automatic point_t edge_crossing(point_t p, point_t c, clip_edge_e e);
    point_t r;
    longint b;
    b = edge_bound(e);
    if (e == EdgeLeft || e == EdgeRight) begin
      r.x = b;
      r.y = (c.x == p.x) ? p.y : p.y + ((c.y - p.y) * (b - p.x)) / (c.x - p.x);
    end else begin
      r.y = b;
      r.x = (c.y == p.y) ? p.x : p.x + ((c.x - p.x) * (b - p.y)) / (c.y - p.y);
    end
    return r;
  endfunction

  function automatic void clip_against(ref point_t pts[$], input clip_edge_e e);
    point_t kept[$];
    point_t prev;
    bit prev_in;
    bit cur_in;
    if (pts.size() == 0) return;
    prev = pts[pts.size()-1];
    prev_in = on_inner_side(prev, e);
    foreach (pts[i]) begin
      cur_in = on_inner_side(pts[i], e);
      // drop anything past the store depth
      if (cur_in != prev_in && kept.size() < StoreDepth)
        kept = {kept, edge_crossing(prev, pts[i], e)};
      if (cur_in && kept.size() < StoreDepth) kept = {kept, pts[i]};
      prev = pts[i];
      prev_in = cur_in;
    end
    pts = kept;
  endfunction

  // Run the four passes over the loaded polygon and queue what must come out.
  function automatic void predict_clipped_polygon();
    point_t pts[$];
    out_item_t o;
    pts = polygon_pts;
    clip_against(pts, EdgeLeft);
    clip_against(pts, EdgeRight);
    clip_against(pts, EdgeBottom);
    clip_against(pts, EdgeTop);
    o = '0;
    o.vertices_dropped = polygon_overflow;
    if (pts.size() == 0) begin
      o.end_of_polygon = 1'b1;
      o.fully_clipped = 1'b1;
      clipped_expect = {clipped_expect, o};
      empty_markers++;
    end else begin
      foreach (pts[i]) begin
        o.clipped_x = pts[i].x[CoordW-1:0];
        o.clipped_y = pts[i].y[CoordW-1:0];
        o.end_of_polygon = (i == pts.size() - 1);
        clipped_expect = {clipped_expect, o};
      end
    end
    polygon_pts.delete();
    polygon_overflow = 1'b0;
    polygons_done++;
  endfunction

  // ------------------------------------------------------ driver and monitor

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive on the falling edge; advance only after the last item was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_took) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (vertex_feed.size() > 0) begin
          in_data <= vertex_feed.pop_front();
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      // receiver stall
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= pick_gap();
      end
    end
  end

  // Sample on the rising edge: take vertices into the predictor, check results.
  always @(posedge clk_i) begin
    out_item_t want;
    point_t p;
    in_took = in_valid && !in_stall;
    if (in_took) begin
      vertices_taken++;
      if (polygon_pts.size() < MaxVertices) begin
        p.x = longint'(in_data.vertex_x);
        p.y = longint'(in_data.vertex_y);
        polygon_pts = {polygon_pts, p};
      end else begin
        polygon_overflow = 1'b1;
      end
      if (in_data.final_vertex) predict_clipped_polygon();
    end
    if (out_valid && !out_stall) begin
      results_seen++;
      if (clipped_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected clipped vertex %p", out_data);
      end else begin
        want = clipped_expect.pop_front();
        if (out_data.clipped_x !== want.clipped_x || out_data.clipped_y !== want.clipped_y ||
            out_data.end_of_polygon !== want.end_of_polygon ||
            out_data.fully_clipped !== want.fully_clipped ||
            out_data.vertices_dropped !== want.vertices_dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: clipped vertex mismatch, expected %p, got %p", want, out_data);
        end
      end
    end
    // watchdog: count cycles in which nothing moves
    if (rst_ni) begin
      if (in_took || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("ERROR: watchdog expired, %0d results still pending", clipped_expect.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_bound(logic [CfgIdxW-1:0] idx, int value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[BoundW-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgLeft:   win_left = value[BoundW-1:0];
      CfgBottom: win_bottom = value[BoundW-1:0];
      CfgRight:  win_right = value[BoundW-1:0];
      default:   win_top = value[BoundW-1:0];
    endcase
  endtask

  task automatic set_window(int l, int b, int r, int t);
    write_bound(CfgLeft, l);
    write_bound(CfgBottom, b);
    write_bound(CfgRight, r);
    write_bound(CfgTop, t);
  endtask

  function automatic void add_vertex(longint x, longint y, bit last);
    in_item_t v;
    v.vertex_x = x[CoordW-1:0];
    v.vertex_y = y[CoordW-1:0];
    v.final_vertex = last;
    vertex_feed = {vertex_feed, v};
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Polygon scattered around the current window so that edges get crossed.
  function automatic void add_random_polygon(int n);
    longint lo_x, lo_y, span_x, span_y, margin;
    lo_x = longint'(win_left) * 256;
    lo_y = longint'(win_bottom) * 256;
    span_x = (longint'(win_right) - longint'(win_left)) * 256;
    span_y = (longint'(win_top) - longint'(win_bottom)) * 256;
    if (span_x < 256) span_x = 256;
    if (span_y < 256) span_y = 256;
    margin = span_x / 2 + 512;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        add_vertex(longint'($signed($urandom_range(0, 24'hFFFFFF) - 24'sd0) << 8) >>> 8,
                   longint'(signed'(24'($urandom))), i == n - 1);
      else
        add_vertex(clamp24(lo_x - margin + $urandom_range(0, 32'(span_x + 2 * margin))),
                   clamp24(lo_y - margin + $urandom_range(0, 32'(span_y + 2 * margin))),
                   i == n - 1);
    end
  endfunction

  // Let the feed empty and every predicted result arrive, then settle.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (vertex_feed.size() > 0 || in_valid || clipped_expect.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int n;
    int l, b;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset window 0..639 x 0..479.
    no_idle = 1'b1;
    add_vertex(25600, 25600, 0);               // square fully inside
    add_vertex(51200, 25600, 0);
    add_vertex(51200, 51200, 0);
    add_vertex(25600, 51200, 1);
    add_vertex(-25600, -12800, 0);             // triangle crossing every edge
    add_vertex(200000, 60000, 0);
    add_vertex(60000, 150000, 1);
    add_vertex(-8388608, -8388608, 0);         // coordinate extremes, all outside
    add_vertex(8388607, -8388608, 0);
    add_vertex(8388607, 8388607, 1);
    add_vertex(1000, 2000, 1);                 // single vertex
    add_vertex(-5000, 3000, 0);                // two vertices, one outside
    add_vertex(0, 122624, 1);                  // sits on the boundary
    wait_idle();

    // Too many vertices: the final one lands beyond the limit.
    no_idle = 1'b0;
    for (int i = 0; i < MaxVertices + 3; i++)
      add_vertex(12800 + 2560 * i, (i % 2) ? -4000 : 90000, i == MaxVertices + 2);
    wait_idle();

    // Widest possible window with extreme coordinates.
    set_window(-32768, -32768, 32767, 32767);
    add_vertex(-8388608, -8388608, 0);
    add_vertex(8388607, 0, 0);
    add_vertex(0, 8388607, 1);
    wait_idle();

    // Degenerate window: left beyond right.
    set_window(100, 0, -100, 479);
    add_vertex(0, 0, 0);
    add_vertex(25600, 0, 0);
    add_vertex(0, 25600, 1);
    wait_idle();

    // Random windows with bursts of random polygons.
    while (vertices_taken < TargetItems) begin
      l = $urandom_range(0, 4000) - 2000;
      b = $urandom_range(0, 4000) - 2000;
      if ($urandom_range(7) == 0)
        set_window(l, b, l - $urandom_range(1, 50), b + $urandom_range(0, 800));
      else
        set_window(l, b, l + $urandom_range(0, 1500), b + $urandom_range(0, 1500));
      no_idle = ($urandom_range(3) == 0);
      repeat ($urandom_range(2, 5)) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(MaxVertices + 1, MaxVertices + 4)
                                     : $urandom_range(1, MaxVertices);
        if (vertices_taken + vertex_feed.size() < TargetItems) add_random_polygon(n);
      end
      wait_idle();
    end

    $display("Run covered %0d vertices in %0d polygons, %0d clipped results checked",
             vertices_taken, polygons_done, results_seen);
    $display("(%0d fully clipped), over several clip windows including extremes",
             empty_markers);
    if (mismatches == 0 && clipped_expect.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, clipped_expect.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
